// ===== rtl/core/jsu_pkg.sv =====
// jsu_pkg: types, character codes and decode helpers for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
  localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
  localparam logic [2:0] HEX_LAST = 3'd3;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_QUOTE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  // up to four results for one input byte, count 1..4
  typedef struct packed {
    result_t [3:0] slot;
    logic [2:0]    count;
  } bundle_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } map_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
  } utf8_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  function automatic map_t simple_escape(input logic [7:0] c);
    map_t m;
    m.valid = 1'b1;
    case (c)
      CH_QUOTE:  m.data = CH_QUOTE;
      CH_BSLASH: m.data = CH_BSLASH;
      CH_SLASH:  m.data = CH_SLASH;
      8'h62:     m.data = 8'h08;
      8'h66:     m.data = 8'h0C;
      8'h6E:     m.data = 8'h0A;
      8'h72:     m.data = 8'h0D;
      8'h74:     m.data = 8'h09;
      default: begin
        m.valid = 1'b0;
        m.data  = 8'h00;
      end
    endcase
    return m;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp < CP_TWO_BYTE) begin
      u.bytes[0] = cp[7:0];
      u.count    = 2'd1;
    end else if (cp < CP_THREE_BYTE) begin
      u.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      u.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
      u.count    = 2'd2;
    end else begin
      u.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      u.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
      u.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
      u.count    = 2'd3;
    end
    return u;
  endfunction

endpackage

// ===== rtl/core/jsu_front.sv =====
// jsu_front: takes raw string bytes, tracks escape mode and builds at most one result bundle per byte.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      in_byte,
  input  logic            q_full,
  output logic            full,
  output logic            q_push,
  output jsu_pkg::bundle_t q_data
);

  jsu_pkg::mode_t mode, mode_next;
  logic [2:0]     hex_count, hex_count_next;
  logic [15:0]    code_point, code_point_next;

  logic             accept;
  jsu_pkg::hex_t    hex;
  jsu_pkg::map_t    esc;
  logic [15:0]      cp_shift;
  jsu_pkg::utf8_t   enc_cur, enc_shift;
  logic             plain_has;
  jsu_pkg::result_t plain_res;
  logic             is_bslash, is_quote, is_nul, is_u;

  assign accept    = push && !q_full;
  assign full      = q_full;
  assign hex       = jsu_pkg::hex_digit(in_byte);
  assign esc       = jsu_pkg::simple_escape(in_byte);
  assign cp_shift  = {code_point[11:0], hex.value};
  assign enc_cur   = jsu_pkg::utf8_encode(code_point);
  assign enc_shift = jsu_pkg::utf8_encode(cp_shift);
  assign is_bslash = (in_byte == jsu_pkg::CH_BSLASH);
  assign is_quote  = (in_byte == jsu_pkg::CH_QUOTE);
  assign is_nul    = (in_byte == jsu_pkg::CH_NUL);
  assign is_u      = (in_byte == jsu_pkg::CH_U);

  always_comb begin
    plain_has      = !is_bslash;
    plain_res.data = 8'h00;
    if (is_nul) begin
      plain_res.kind = jsu_pkg::KIND_ERROR;
    end else if (is_quote) begin
      plain_res.kind = jsu_pkg::KIND_QUOTE;
    end else begin
      plain_res.kind = jsu_pkg::KIND_BYTE;
      plain_res.data = in_byte;
    end
  end

  // next state
  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    case (mode)
      jsu_pkg::MODE_ESC: begin
        if (esc.valid) begin
          mode_next = jsu_pkg::MODE_PLAIN;
        end else if (is_u) begin
          mode_next       = jsu_pkg::MODE_HEX;
          hex_count_next  = 3'd0;
          code_point_next = 16'h0000;
        end else begin
          mode_next       = jsu_pkg::MODE_PLAIN;
          hex_count_next  = 3'd0;
          code_point_next = 16'h0000;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (hex.valid && !hex_count[2]) begin
          code_point_next = cp_shift;
          hex_count_next  = hex_count + 3'd1;
          if (hex_count == jsu_pkg::HEX_LAST) begin
            mode_next       = jsu_pkg::MODE_PLAIN;
            hex_count_next  = 3'd0;
            code_point_next = 16'h0000;
          end
        end else begin
          hex_count_next  = 3'd0;
          code_point_next = 16'h0000;
          mode_next       = is_bslash ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_PLAIN;
        end
      end
      default: begin
        if (is_bslash) begin
          mode_next = jsu_pkg::MODE_ESC;
        end else begin
          mode_next = jsu_pkg::MODE_PLAIN;
          if (is_nul || is_quote) begin
            hex_count_next  = 3'd0;
            code_point_next = 16'h0000;
          end
        end
      end
    endcase
  end

  // result bundle
  always_comb begin
    q_data = '0;
    case (mode)
      jsu_pkg::MODE_ESC: begin
        if (esc.valid) begin
          q_data.slot[0] = '{data: esc.data, kind: jsu_pkg::KIND_BYTE};
          q_data.count   = 3'd1;
        end else if (!is_u) begin
          q_data.slot[0] = '{data: 8'h00, kind: jsu_pkg::KIND_ERROR};
          q_data.count   = 3'd1;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (hex.valid && !hex_count[2]) begin
          if (hex_count == jsu_pkg::HEX_LAST) begin
            for (int i = 0; i < 3; i++) begin
              q_data.slot[i] = '{data: enc_shift.bytes[i], kind: jsu_pkg::KIND_BYTE};
            end
            q_data.count = {1'b0, enc_shift.count};
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            q_data.slot[i] = '{data: enc_cur.bytes[i], kind: jsu_pkg::KIND_BYTE};
          end
          if (plain_has) begin
            q_data.slot[enc_cur.count] = plain_res;
          end
          q_data.count = {1'b0, enc_cur.count} + {2'b00, plain_has};
        end
      end
      default: begin
        if (plain_has) begin
          q_data.slot[0] = plain_res;
          q_data.count   = 3'd1;
        end
      end
    endcase
  end

  assign q_push = accept && (q_data.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= jsu_pkg::MODE_PLAIN;
      hex_count  <= 3'd0;
      code_point <= 16'h0000;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
    end
  end

endmodule

// ===== rtl/core/jsu_queue.sv =====
// jsu_queue: small first-in first-out store of result bundles between front and back.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  jsu_pkg::bundle_t wr_data,
  input  logic             rd,
  output jsu_pkg::bundle_t rd_data,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  jsu_pkg::bundle_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             do_wr, do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/jsu_back.sv =====
// jsu_back: unpacks result bundles into single results on the output side, one per cycle
// while pop is high. Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::bundle_t q_data,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic             run_last
);

  jsu_pkg::bundle_t cur;
  logic             cur_valid;
  logic [1:0]       idx;
  logic             last, take, load;
  jsu_pkg::result_t res;

  assign last  = (idx == 2'(cur.count - 3'd1));
  assign take  = pop && cur_valid;
  assign load  = !cur_valid || (take && last);
  assign q_pop = load && !q_empty;
  assign res   = cur.slot[idx];

  assign empty    = !cur_valid;
  assign out_byte = res.data;
  assign kind     = res.kind;
  assign run_last = last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// ===== rtl/core/json_string_unescaper.sv =====
// JSON string unescaper top level: front decoder, bundle queue and result unpacker.
// An accepted byte's bundle is written into the bundle queue, then loaded into the unpacker's
// current-bundle register, from which its results are shown and popped.
// Throughput: one byte per cycle while full is low; a byte that gives several results is popped
// one result at a time, and the bundle queue absorbs such bursts while the front keeps accepting.
// Reset (rst, synchronous): plain mode, empty queue, no result showing.
`timescale 1ns / 1ps

module json_string_unescaper #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       run_last
);

  jsu_pkg::bundle_t wr_data, rd_data;
  logic             q_wr, q_rd, q_full, q_empty;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_byte (in_byte),
    .q_full  (q_full),
    .full    (full),
    .q_push  (q_wr),
    .q_data  (wr_data)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (wr_data),
    .rd      (q_rd),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (rd_data),
    .q_empty  (q_empty),
    .q_pop    (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .kind     (kind),
    .run_last (run_last)
  );

endmodule

// ===== rtl/core/jsu_checker.sv =====
// jsu_checker: port-level assertions for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescaper.
`timescale 1ns / 1ps

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic       run_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("results or full showing after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(out_byte) && $stable(kind) && $stable(run_last))
    else $error("waiting result changed");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != jsu_pkg::KIND_BYTE |-> out_byte == 8'h00 && run_last)
    else $error("quote or error result not zero or not last");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> kind <= jsu_pkg::KIND_ERROR)
    else $error("undefined result kind");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .kind     (kind),
  .run_last (run_last)
);

// ===== tb/json_string_unescaper_checker.sv =====
// Checker for json_string_unescaper: watches the push and pop handshakes, decodes each
// accepted byte on its own and compares every popped result field by field.
// Depends on jsu_pkg for character codes and the mode and kind enums.
`timescale 1ns / 1ps

module json_string_unescaper_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic [1:0] kind,
  input  logic       run_last,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  typedef struct packed {
    logic [7:0]      data;
    jsu_pkg::kind_t  kind;
    logic            last;
  } decoded_t;

  decoded_t       decoded_q[$];
  decoded_t       step_res[4];
  int             step_n;
  int             fails = 0;
  int             n_checked = 0;
  jsu_pkg::mode_t mode = jsu_pkg::MODE_PLAIN;
  logic [2:0]     digits = '0;
  logic [15:0]    cp = '0;

  task automatic restart();
    mode   = jsu_pkg::MODE_PLAIN;
    digits = '0;
    cp     = '0;
  endtask

  task automatic add_result(input logic [7:0] data, input jsu_pkg::kind_t k);
    step_res[step_n] = '{data: data, kind: k, last: 1'b0};
    step_n++;
  endtask

  task automatic emit_code_point(input logic [15:0] v);
    if (v < jsu_pkg::CP_TWO_BYTE) begin
      add_result(v[7:0], jsu_pkg::KIND_BYTE);
    end else if (v < jsu_pkg::CP_THREE_BYTE) begin
      add_result(jsu_pkg::UTF8_LEAD2 | {3'b000, v[10:6]}, jsu_pkg::KIND_BYTE);
      add_result(jsu_pkg::UTF8_CONT | {2'b00, v[5:0]}, jsu_pkg::KIND_BYTE);
    end else begin
      add_result(jsu_pkg::UTF8_LEAD3 | {4'b0000, v[15:12]}, jsu_pkg::KIND_BYTE);
      add_result(jsu_pkg::UTF8_CONT | {2'b00, v[11:6]}, jsu_pkg::KIND_BYTE);
      add_result(jsu_pkg::UTF8_CONT | {2'b00, v[5:0]}, jsu_pkg::KIND_BYTE);
    end
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == jsu_pkg::CH_NUL) begin
      add_result(8'h00, jsu_pkg::KIND_ERROR);
      restart();
    end else if (c == jsu_pkg::CH_QUOTE) begin
      add_result(8'h00, jsu_pkg::KIND_QUOTE);
      restart();
    end else if (c == jsu_pkg::CH_BSLASH) begin
      mode = jsu_pkg::MODE_ESC;
    end else begin
      add_result(c, jsu_pkg::KIND_BYTE);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c);
    logic [3:0] nib;
    logic       is_hex;
    logic       simple;
    logic [7:0] esc;
    decoded_t   r;
    step_n = 0;
    is_hex = 1'b1;
    nib    = '0;
    if (c >= "0" && c <= "9") begin
      nib = c[3:0];
    end else if (c >= "a" && c <= "f") begin
      nib = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      nib = 4'(c - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    case (mode)
      jsu_pkg::MODE_ESC: begin
        simple = 1'b1;
        esc    = 8'h00;
        case (c)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: esc = c;
          "b": esc = 8'h08;
          "f": esc = 8'h0C;
          "n": esc = 8'h0A;
          "r": esc = 8'h0D;
          "t": esc = 8'h09;
          default: simple = 1'b0;
        endcase
        if (simple) begin
          add_result(esc, jsu_pkg::KIND_BYTE);
          mode = jsu_pkg::MODE_PLAIN;
        end else if (c == jsu_pkg::CH_U) begin
          mode   = jsu_pkg::MODE_HEX;
          digits = '0;
          cp     = '0;
        end else begin
          add_result(8'h00, jsu_pkg::KIND_ERROR);
          restart();
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (is_hex && digits < 3'd4) begin
          cp     = {cp[11:0], nib};
          digits = digits + 3'd1;
          if (digits >= 3'd4) begin
            emit_code_point(cp);
            restart();
          end
        end else begin
          emit_code_point(cp);
          restart();
          plain_char(c);
        end
      end
      default: begin
        mode = jsu_pkg::MODE_PLAIN;
        plain_char(c);
      end
    endcase
    for (int i = 0; i < step_n; i++) begin
      r      = step_res[i];
      r.last = (i == step_n - 1);
      decoded_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    decoded_t want;
    if (rst) begin
      restart();
      decoded_q.delete();
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $error("result with no request pending: out_byte %h kind %0d run_last %b",
                 out_byte, kind, run_last);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          n_checked++;
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            fails++;
          end
          if (kind !== 2'(want.kind)) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            fails++;
          end
          if (run_last !== want.last) begin
            $error("run_last: expected %b, got %b", want.last, run_last);
            fails++;
          end
        end
      end
      if (push && !full) begin
        decode_byte(in_byte);
      end
    end
    fail_count <= fails;
    checked    <= n_checked;
    pending    <= decoded_q.size();
  end

endmodule

// ===== tb/json_string_unescaper_tb.sv =====
// Testbench top for json_string_unescaper: drives directed and random string bodies with
// random gaps and pop stalls, and reports the verdict from json_string_unescaper_checker.
// Depends on jsu_pkg, the block and the checker.
`timescale 1ns / 1ps

module json_string_unescaper_tb;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       run_last;
  int         fail_count;
  int         pending;
  int         checked;
  int         sent = 0;
  int         directed_n;
  logic [7:0] stream_q[$];

  json_string_unescaper i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .kind     (kind),
    .run_last (run_last)
  );

  json_string_unescaper_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .kind       (kind),
    .run_last   (run_last),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] esc_char(input int idx);
    case (idx)
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    if ($urandom_range(0, 1)) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  task automatic add_unicode(input int n, input logic [15:0] v);
    stream_q.push_back(jsu_pkg::CH_BSLASH);
    stream_q.push_back(jsu_pkg::CH_U);
    for (int k = n - 1; k >= 0; k--) stream_q.push_back(hex_char(v[4*k +: 4]));
  endtask

  task automatic add_piece();
    int          r;
    logic [7:0]  b;
    logic [15:0] v;
    bit          known;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       v = 16'($urandom_range(16'h0000, 16'h007F));
      1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
      default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
    if (r < 40) begin
      do b = 8'($urandom_range(1, 255));
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
      stream_q.push_back(b);
    end else if (r < 58) begin
      stream_q.push_back(jsu_pkg::CH_BSLASH);
      stream_q.push_back(esc_char($urandom_range(0, 7)));
    end else if (r < 73) begin
      add_unicode(4, v);
    end else if (r < 81) begin
      add_unicode($urandom_range(0, 3), v);
      do b = 8'($urandom_range(0, 255));
      while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
      stream_q.push_back(b);
    end else if (r < 89) begin
      stream_q.push_back(jsu_pkg::CH_QUOTE);
    end else if (r < 93) begin
      stream_q.push_back(jsu_pkg::CH_BSLASH);
      do begin
        b     = 8'($urandom_range(0, 255));
        known = (b == jsu_pkg::CH_U);
        for (int i = 0; i < 8; i++) if (esc_char(i) == b) known = 1'b1;
      end while (known);
      stream_q.push_back(b);
    end else if (r < 95) begin
      stream_q.push_back(jsu_pkg::CH_NUL);
    end else begin
      stream_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  // receiver: random pops, calm windows, and one long hold to back up the queue
  initial begin : drain
    int stall;
    int cyc;
    bit held;
    stall = 0;
    cyc   = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!held && sent >= 150) begin
        held  = 1'b1;
        stall = 80;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if ((cyc / 128) % 4 != 1) stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    stream_q.push_back(8'hFF);
    for (int i = 0; i < 8; i++) begin
      stream_q.push_back(jsu_pkg::CH_BSLASH);
      stream_q.push_back(esc_char(i));
    end
    add_unicode(4, 16'hFFFF);
    add_unicode(1, 16'h0007);
    stream_q.push_back(jsu_pkg::CH_QUOTE);
    stream_q.push_back(jsu_pkg::CH_BSLASH);
    stream_q.push_back("x");
    stream_q.push_back(jsu_pkg::CH_NUL);
    directed_n = stream_q.size();
    while (stream_q.size() < 460) add_piece();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (stream_q[i]) begin
      send_byte(stream_q[i], ((i / 50) % 4 == 1) ? 0 : pick_gap());
    end
    push <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes (%0d directed), checked %0d decoded results.",
             sent, directed_n, checked);
    $display("Covered simple and \\u escapes of every length, quotes, NUL, bad escapes, stalls.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
